// ===== src/vsf_pkg.sv =====
// Shared types, codes and the axis clamp for the viewport scroll follower.
package vsf_pkg;

	// Item kinds
	typedef enum logic [1:0] {
		KIND_TICK       = 2'd0,
		KIND_MOVE_TO    = 2'd1,
		KIND_SET_CENTRE = 2'd2,
		KIND_SET_CORNER = 2'd3
	} kind_t;

	// Working configuration: edges, bounds spans and effective view sizes
	typedef struct packed {
		logic signed [15:0] edge_x;
		logic signed [15:0] edge_y;
		logic [14:0]        span_x;
		logic [14:0]        span_y;
		logic [14:0]        size_x;
		logic [14:0]        size_y;
	} cfg_t;

	// Classified word passed from front to back
	typedef struct packed {
		kind_t              kind;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [7:0]         speed;
	} cmd_t;

	// Result word
	typedef struct packed {
		logic signed [15:0] view_x;
		logic signed [15:0] view_y;
		logic               moving;
	} res_t;

	// Clamp one axis into [edge, edge + span - size], far edge wins, then saturate to 16 bits
	function automatic logic signed [15:0] clamp_axis(
		input logic signed [18:0] v,
		input logic signed [15:0] edge_v,
		input logic [14:0]        span,
		input logic [14:0]        size
	);
		logic signed [18:0] lo;
		logic signed [18:0] far;
		logic signed [18:0] r;
		lo  = {{3{edge_v[15]}}, edge_v};
		far = lo + $signed({4'b0000, span});
		r   = (v < lo) ? lo : v;
		if (r + $signed({4'b0000, size}) > far) begin
			r = far - $signed({4'b0000, size});
		end
		if (r[18] && (r[17:15] != 3'b111)) begin
			clamp_axis = 16'sh8000;
		end else if (!r[18] && (r[17:15] != 3'b000)) begin
			clamp_axis = 16'sh7fff;
		end else begin
			clamp_axis = r[15:0];
		end
	endfunction

endpackage

// ===== src/viewport_scroll_follower.sv =====
// Top level: configuration registers, front end, command queue and back end.
// A word goes through the command queue, then the back end, then the result queue.
// Throughput: one word per cycle on each side, while the queue it feeds has room.
// Two-entry queues on both sides let input and result sides stall on their own.
// Reset (arst_n low): registers, origin, goals, speed clear to zero; queues empty.
module viewport_scroll_follower (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         kind,
	input  logic signed [15:0] coord_x,
	input  logic signed [15:0] coord_y,
	input  logic [7:0]         step_speed,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] view_x,
	output logic signed [15:0] view_y,
	output logic               moving
);
	import vsf_pkg::*;

	localparam logic [2:0] REG_BOUNDS_LEFT   = 3'd0;
	localparam logic [2:0] REG_BOUNDS_TOP    = 3'd1;
	localparam logic [2:0] REG_BOUNDS_WIDTH  = 3'd2;
	localparam logic [2:0] REG_BOUNDS_HEIGHT = 3'd3;
	localparam logic [2:0] REG_VIEW_WIDTH    = 3'd4;
	localparam logic [2:0] REG_VIEW_HEIGHT   = 3'd5;

	logic signed [15:0] left_q, top_q;
	logic [14:0]        bw_q, bh_q, vw_q, vh_q;
	cfg_t               cfg;
	cmd_t               cmd_in, cmd_out;
	logic               cmd_empty, cmd_pop;
	res_t               res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= 16'sd0;
			top_q  <= 16'sd0;
			bw_q   <= 15'd0;
			bh_q   <= 15'd0;
			vw_q   <= 15'd0;
			vh_q   <= 15'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BOUNDS_LEFT:   left_q <= cfg_data;
				REG_BOUNDS_TOP:    top_q  <= cfg_data;
				REG_BOUNDS_WIDTH:  bw_q   <= cfg_data[14:0];
				REG_BOUNDS_HEIGHT: bh_q   <= cfg_data[14:0];
				REG_VIEW_WIDTH:    vw_q   <= cfg_data[14:0];
				REG_VIEW_HEIGHT:   vh_q   <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Effective view size is limited by the bounds size
	always_comb begin
		cfg.edge_x = left_q;
		cfg.edge_y = top_q;
		cfg.span_x = bw_q;
		cfg.span_y = bh_q;
		cfg.size_x = (vw_q > bw_q) ? bw_q : vw_q;
		cfg.size_y = (vh_q > bh_q) ? bh_q : vh_q;
	end

	vsf_front u_front (
		.kind       (kind_t'(kind)),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.step_speed (step_speed),
		.cfg        (cfg),
		.cmd        (cmd_in)
	);

	vsf_cmd_queue u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	vsf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.pop       (pop),
		.empty     (empty),
		.res       (res)
	);

	assign view_x = res.view_x;
	assign view_y = res.view_y;
	assign moving = res.moving;

endmodule

// ===== src/vsf_front.sv =====
// Front end: classifies an incoming item and clamps its placement point.
module vsf_front (
	input  vsf_pkg::kind_t      kind,
	input  logic signed [15:0]  coord_x,
	input  logic signed [15:0]  coord_y,
	input  logic [7:0]          step_speed,
	input  vsf_pkg::cfg_t       cfg,
	output vsf_pkg::cmd_t       cmd
);
	import vsf_pkg::*;

	logic [13:0]        half_x;
	logic [13:0]        half_y;
	logic signed [18:0] pt_x;
	logic signed [18:0] pt_y;

	// Centered kinds pull the point back by half the view size
	always_comb begin
		half_x = 14'd0;
		half_y = 14'd0;
		if (kind inside {KIND_MOVE_TO, KIND_SET_CENTRE}) begin
			half_x = cfg.size_x[14:1];
			half_y = cfg.size_y[14:1];
		end
		pt_x = {{3{coord_x[15]}}, coord_x} - $signed({5'b00000, half_x});
		pt_y = {{3{coord_y[15]}}, coord_y} - $signed({5'b00000, half_y});
	end

	// Clamped placement word
	always_comb begin
		cmd.kind  = kind;
		cmd.pos_x = clamp_axis(pt_x, cfg.edge_x, cfg.span_x, cfg.size_x);
		cmd.pos_y = clamp_axis(pt_y, cfg.edge_y, cfg.span_y, cfg.size_y);
		cmd.speed = step_speed;
	end

endmodule

// ===== src/vsf_cmd_queue.sv =====
// Two-entry word queue between the front end and the back end.
module vsf_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  vsf_pkg::cmd_t wdata,
	output logic          full,
	input  logic          pop,
	output vsf_pkg::cmd_t rdata,
	output logic          empty
);
	import vsf_pkg::*;

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop) count_q <= count_q + 2'd1;
			else if (do_pop && !do_push) count_q <= count_q - 2'd1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("command queue count out of range");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 2'd1))
		else $error("command queue lost a word");

endmodule

// ===== src/vsf_back.sv =====
// Back end: holds origin, goals and speed, executes words and queues results.
module vsf_back (
	input  logic          clk,
	input  logic          arst_n,
	input  vsf_pkg::cfg_t cfg,
	input  vsf_pkg::cmd_t cmd,
	input  logic          cmd_empty,
	output logic          cmd_pop,
	input  logic          pop,
	output logic          empty,
	output vsf_pkg::res_t res
);
	import vsf_pkg::*;

	logic signed [15:0] origin_x_q, origin_y_q, goal_x_q, goal_y_q;
	logic [7:0]         speed_q;
	logic signed [15:0] origin_x_d, origin_y_d, goal_x_d, goal_y_d;
	logic [7:0]         speed_d;
	logic signed [15:0] step_x, step_y;

	res_t       res_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       res_space;
	logic       exec;
	logic       res_pop;

	// One axis step toward the goal, snapping when closer than the speed
	function automatic logic signed [15:0] step_axis(
		input logic signed [15:0] pos,
		input logic signed [15:0] goal,
		input logic [7:0]         spd,
		input logic signed [15:0] edge_v,
		input logic [14:0]        span,
		input logic [14:0]        size
	);
		logic signed [18:0] p;
		logic signed [18:0] g;
		logic signed [18:0] d;
		logic signed [18:0] s;
		logic signed [18:0] nv;
		p = {{3{pos[15]}}, pos};
		g = {{3{goal[15]}}, goal};
		d = g - p;
		s = $signed({11'd0, spd});
		if (!d[18]) nv = (d < s) ? g : p + s;
		else nv = (d > -s) ? g : p - s;
		if (d == 19'sd0) step_axis = pos;
		else step_axis = clamp_axis(nv, edge_v, span, size);
	endfunction

	assign res_pop   = pop && !empty;
	assign empty     = (count_q == 2'd0);
	assign res_space = (count_q != 2'd2) || res_pop;
	assign exec      = !cmd_empty && res_space;
	assign cmd_pop   = exec;
	assign res       = res_q[rd_ptr_q];

	// Tick steps for both axes
	always_comb begin
		step_x = step_axis(origin_x_q, goal_x_q, speed_q, cfg.edge_x, cfg.span_x, cfg.size_x);
		step_y = step_axis(origin_y_q, goal_y_q, speed_q, cfg.edge_y, cfg.span_y, cfg.size_y);
	end

	// Next state per kind
	always_comb begin
		origin_x_d = origin_x_q;
		origin_y_d = origin_y_q;
		goal_x_d   = goal_x_q;
		goal_y_d   = goal_y_q;
		speed_d    = speed_q;
		case (cmd.kind)
			KIND_TICK: begin
				if (speed_q != 8'd0) begin
					origin_x_d = step_x;
					origin_y_d = step_y;
					// blocked axis gives up its goal
					if ((goal_x_q != origin_x_q) && (step_x == origin_x_q)) goal_x_d = step_x;
					if ((goal_y_q != origin_y_q) && (step_y == origin_y_q)) goal_y_d = step_y;
					if ((step_x == goal_x_d) && (step_y == goal_y_d)) speed_d = 8'd0;
				end
			end
			KIND_MOVE_TO: begin
				goal_x_d = cmd.pos_x;
				goal_y_d = cmd.pos_y;
				speed_d  = cmd.speed;
			end
			KIND_SET_CENTRE: begin
				origin_x_d = cmd.pos_x;
				origin_y_d = cmd.pos_y;
				goal_x_d   = 16'sd0;
				goal_y_d   = 16'sd0;
				speed_d    = 8'd0;
			end
			KIND_SET_CORNER: begin
				origin_x_d = cmd.pos_x;
				origin_y_d = cmd.pos_y;
			end
			default: begin
				speed_d = speed_q;
			end
		endcase
	end

	// Architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= 16'sd0;
			origin_y_q <= 16'sd0;
			goal_x_q   <= 16'sd0;
			goal_y_q   <= 16'sd0;
			speed_q    <= 8'd0;
		end else if (exec) begin
			origin_x_q <= origin_x_d;
			origin_y_q <= origin_y_d;
			goal_x_q   <= goal_x_d;
			goal_y_q   <= goal_y_d;
			speed_q    <= speed_d;
		end
	end

	// Result queue storage
	always_ff @(posedge clk) begin
		if (exec) begin
			res_q[wr_ptr_q] <= '{view_x: origin_x_d, view_y: origin_y_d,
				moving: (speed_d != 8'd0)};
		end
	end

	// Result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (exec) wr_ptr_q <= ~wr_ptr_q;
			if (res_pop) rd_ptr_q <= ~rd_ptr_q;
			if (exec && !res_pop) count_q <= count_q + 2'd1;
			else if (res_pop && !exec) count_q <= count_q - 2'd1;
		end
	end

	a_centre_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && cmd.kind == KIND_SET_CENTRE) |=> (speed_q == 8'd0 && goal_x_q == 16'sd0))
		else $error("set_centre left motion active");

	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && cmd.kind == KIND_TICK && speed_q == 8'd0)
		|=> ($stable(origin_x_q) && $stable(origin_y_q)))
		else $error("idle tick moved the origin");

endmodule

// ===== bench/tb_viewport_scroll_follower.sv =====
// Self-checking testbench for the viewport scroll follower.
module tb_viewport_scroll_follower;
	import vsf_pkg::*;

	// Register indexes on the config port
	localparam logic [2:0] REG_BOUNDS_LEFT   = 3'd0;
	localparam logic [2:0] REG_BOUNDS_TOP    = 3'd1;
	localparam logic [2:0] REG_BOUNDS_WIDTH  = 3'd2;
	localparam logic [2:0] REG_BOUNDS_HEIGHT = 3'd3;
	localparam logic [2:0] REG_VIEW_WIDTH    = 3'd4;
	localparam logic [2:0] REG_VIEW_HEIGHT   = 3'd5;

	// Cycles without any word accepted or result taken before the run is declared hung
	localparam int IDLE_LIMIT = 4000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               push;
	logic               full;
	logic [1:0]         kind;
	logic signed [15:0] coord_x;
	logic signed [15:0] coord_y;
	logic [7:0]         step_speed;
	logic               empty;
	logic               pop;
	logic signed [15:0] view_x;
	logic signed [15:0] view_y;
	logic               moving;

	viewport_scroll_follower i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.full       (full),
		.kind       (kind),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.step_speed (step_speed),
		.empty      (empty),
		.pop        (pop),
		.view_x     (view_x),
		.view_y     (view_y),
		.moving     (moving)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predicted configuration and scroll state
	logic signed [15:0] cfg_left, cfg_top;
	logic [14:0]        cfg_span_x, cfg_span_y, cfg_view_w, cfg_view_h;
	logic signed [15:0] cam_x, cam_y, aim_x, aim_y;
	logic [7:0]         cam_speed;

	res_t view_due[$];
	int   send_idle_pct;
	int   pop_stall_pct;
	int   words_sent;
	int   words_checked;
	int   mismatches;
	int   bounds_loaded;
	int   idle_cycles;

	function automatic logic signed [15:0] sat16(int v);
		if (v < -32768) return 16'sh8000;
		if (v > 32767) return 16'sh7fff;
		return v[15:0];
	endfunction

	// Effective view size: requested size capped at the bounds size
	function automatic int extent(logic [14:0] req, logic [14:0] lim);
		return (req > lim) ? int'(lim) : int'(req);
	endfunction

	// Low edge first, then far edge (far edge wins), then 16-bit saturation
	function automatic logic signed [15:0] fit_axis(int v, int lo_edge, int span, int sz);
		int r;
		r = (v < lo_edge) ? lo_edge : v;
		if (r + sz > lo_edge + span) r = lo_edge + span - sz;
		return sat16(r);
	endfunction

	function automatic logic signed [15:0] fit_x(int v);
		return fit_axis(v, int'(cfg_left), int'(cfg_span_x), extent(cfg_view_w, cfg_span_x));
	endfunction

	function automatic logic signed [15:0] fit_y(int v);
		return fit_axis(v, int'(cfg_top), int'(cfg_span_y), extent(cfg_view_h, cfg_span_y));
	endfunction

	// One tick of one axis: step by speed, snap when closer than speed
	function automatic logic signed [15:0] advance_axis(int pos, int aim, int spd, bit is_x);
		int diff;
		int nv;
		diff = aim - pos;
		if (diff == 0) return pos[15:0];
		if (diff > 0) nv = (diff < spd) ? aim : pos + spd;
		else nv = (diff > -spd) ? aim : pos - spd;
		return is_x ? fit_x(nv) : fit_y(nv);
	endfunction

	// Update the predicted state for one accepted word and queue its result
	function automatic void follow_word(kind_t k, logic signed [15:0] cx,
			logic signed [15:0] cy, logic [7:0] spd);
		int                 hw;
		int                 hh;
		logic signed [15:0] ox;
		logic signed [15:0] oy;
		bit                 mx;
		bit                 my;
		res_t               r;
		hw = extent(cfg_view_w, cfg_span_x) / 2;
		hh = extent(cfg_view_h, cfg_span_y) / 2;
		case (k)
			KIND_TICK: begin
				if (cam_speed != 0) begin
					ox = cam_x;
					oy = cam_y;
					mx = (aim_x != ox);
					my = (aim_y != oy);
					cam_x = advance_axis(int'(ox), int'(aim_x), int'(cam_speed), 1'b1);
					cam_y = advance_axis(int'(oy), int'(aim_y), int'(cam_speed), 1'b0);
					// blocked by the clamp: give up on that axis
					if (mx && cam_x == ox) aim_x = cam_x;
					if (my && cam_y == oy) aim_y = cam_y;
					if (cam_x == aim_x && cam_y == aim_y) cam_speed = '0;
				end
			end
			KIND_MOVE_TO: begin
				aim_x = fit_x(int'(cx) - hw);
				aim_y = fit_y(int'(cy) - hh);
				cam_speed = spd;
			end
			KIND_SET_CENTRE: begin
				cam_x = fit_x(int'(cx) - hw);
				cam_y = fit_y(int'(cy) - hh);
				cam_speed = '0;
				aim_x = '0;
				aim_y = '0;
			end
			default: begin
				cam_x = fit_x(int'(cx));
				cam_y = fit_y(int'(cy));
			end
		endcase
		r.view_x = cam_x;
		r.view_y = cam_y;
		r.moving = (cam_speed != 0);
		view_due.push_back(r);
	endfunction

	// Offer one word; push stays high on return so the next word can follow at once
	task automatic send_word(kind_t k, logic signed [15:0] cx, logic signed [15:0] cy,
			logic [7:0] spd);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		kind <= k;
		coord_x <= cx;
		coord_y <= cy;
		step_speed <= spd;
		@(posedge clk);
		while (full) @(posedge clk);
		follow_word(k, cx, cy, spd);
		words_sent++;
	endtask

	// Stop offering words and wait until every expected result has come back
	task automatic drain_results();
		push <= 1'b0;
		while (view_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_BOUNDS_LEFT:   cfg_left = data;
			REG_BOUNDS_TOP:    cfg_top = data;
			REG_BOUNDS_WIDTH:  cfg_span_x = data[14:0];
			REG_BOUNDS_HEIGHT: cfg_span_y = data[14:0];
			REG_VIEW_WIDTH:    cfg_view_w = data[14:0];
			REG_VIEW_HEIGHT:   cfg_view_h = data[14:0];
			default: ;
		endcase
	endtask

	// Load all six registers while idle; unused top bit of 15-bit registers is random
	task automatic load_bounds(int left, int top, int span_x, int span_y, int vw, int vh);
		logic [15:0] l16;
		logic [15:0] t16;
		drain_results();
		l16 = left[15:0];
		t16 = top[15:0];
		write_reg(REG_BOUNDS_LEFT, l16);
		write_reg(REG_BOUNDS_TOP, t16);
		write_reg(REG_BOUNDS_WIDTH, {1'($urandom_range(0, 1)), span_x[14:0]});
		write_reg(REG_BOUNDS_HEIGHT, {1'($urandom_range(0, 1)), span_y[14:0]});
		write_reg(REG_VIEW_WIDTH, {1'($urandom_range(0, 1)), vw[14:0]});
		write_reg(REG_VIEW_HEIGHT, {1'($urandom_range(0, 1)), vh[14:0]});
		cfg_we <= 1'b0;
		@(posedge clk);
		bounds_loaded++;
	endtask

	// Random bounds: mostly modest areas, some full range, some with oversized views
	task automatic pick_bounds();
		int bw;
		int bh;
		case ($urandom_range(0, 5))
			0: load_bounds(int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)),
				int'($urandom_range(0, 32767)), int'($urandom_range(0, 32767)),
				int'($urandom_range(0, 32767)), int'($urandom_range(0, 32767)));
			1: begin
				bw = $urandom_range(0, 300);
				bh = $urandom_range(0, 300);
				load_bounds(int'($urandom_range(0, 4000)) - 2000,
					int'($urandom_range(0, 4000)) - 2000, bw, bh,
					int'($urandom_range(bw, 32767)), int'($urandom_range(bh, 32767)));
			end
			default: begin
				bw = $urandom_range(0, 1500);
				bh = $urandom_range(0, 1500);
				load_bounds(int'($urandom_range(0, 4000)) - 2000,
					int'($urandom_range(0, 4000)) - 2000, bw, bh,
					int'($urandom_range(0, bw)), int'($urandom_range(0, bh)));
			end
		endcase
	endtask

	// A point near the current bounds, or anywhere in 16 bits now and then
	function automatic logic signed [15:0] rand_point(bit is_x);
		int lo_edge;
		int span;
		if ($urandom_range(0, 7) == 0) return 16'($urandom_range(0, 65535));
		lo_edge = is_x ? int'(cfg_left) : int'(cfg_top);
		span = is_x ? int'(cfg_span_x) : int'(cfg_span_y);
		return sat16(lo_edge - 64 + int'($urandom_range(0, span + 128)));
	endfunction

	function automatic logic [7:0] rand_speed();
		case ($urandom_range(0, 9))
			0:       return 8'd0;
			1:       return 8'd255;
			2:       return 8'($urandom_range(0, 255));
			default: return 8'($urandom_range(1, 24));
		endcase
	endfunction

	// Reset values: zero-size bounds pin everything to the origin
	task automatic test_reset_bounds();
		send_word(KIND_SET_CORNER, 16'sh8000, 16'sh7fff, 8'd0);
		send_word(KIND_MOVE_TO, 16'sh7fff, 16'sh8000, 8'd255);
		send_word(KIND_TICK, 16'sh0000, 16'sh0000, 8'd0);
	endtask

	// Field extremes, far-edge clamp, collapsed ranges and 16-bit saturation
	task automatic test_extremes();
		load_bounds(-32768, 32767, 32767, 32767, 100, 32767);
		send_word(KIND_SET_CORNER, 16'sh7fff, 16'sh8000, 8'hff);
		send_word(KIND_SET_CORNER, 16'sh8000, 16'sh7fff, 8'h00);
		send_word(KIND_SET_CENTRE, 16'sh7fff, 16'sh8000, 8'h55);
		send_word(KIND_MOVE_TO, 16'sh8000, 16'sh0000, 8'd255);
		send_word(KIND_TICK, 16'shffff, 16'shffff, 8'hff);
		send_word(KIND_TICK, 16'sh0000, 16'sh0000, 8'h00);
		send_word(KIND_MOVE_TO, 16'sh0000, 16'sh0000, 8'd0);
		send_word(KIND_TICK, 16'sh5555, 16'shaaaa, 8'haa);
		load_bounds(32767, -32768, 32767, 0, 0, 32767);
		send_word(KIND_SET_CORNER, 16'sh7fff, 16'sh7fff, 8'd1);
		send_word(KIND_SET_CENTRE, 16'shffff, 16'shffff, 8'd1);
	endtask

	// Clamp blocks the step after the bounds move; odd and oversized views
	task automatic test_blocked_step();
		load_bounds(0, 0, 200, 200, 41, 40);
		send_word(KIND_SET_CORNER, 16'sd160, 16'sd160, 8'd0);
		send_word(KIND_MOVE_TO, 16'sd20, 16'sd20, 8'd7);
		send_word(KIND_TICK, 16'sd0, 16'sd0, 8'd0);
		// goal now lies outside the new bounds; the ticks stop at their low edge and the blocked axes give up their goals
		load_bounds(150, 150, 200, 200, 41, 40);
		send_word(KIND_TICK, 16'sd0, 16'sd0, 8'd0);
		send_word(KIND_TICK, 16'sd0, 16'sd0, 8'd0);
		send_word(KIND_TICK, 16'sd0, 16'sd0, 8'd0);
		send_word(KIND_SET_CENTRE, 16'sd251, 16'sd251, 8'd0);
		load_bounds(0, 0, 200, 200, 32767, 300);
		send_word(KIND_SET_CENTRE, 16'sd300, 16'sd300, 8'd0);
	endtask

	// Random traffic in two halves, each with its own bounds
	task automatic test_random_traffic(int words, int send_pct, int stall_pct);
		int   done;
		int   ticks;
		kind_t k;
		send_idle_pct = send_pct;
		pop_stall_pct = stall_pct;
		for (int half = 0; half < 2; half++) begin
			pick_bounds();
			done = 0;
			while (done < words / 2) begin
				case ($urandom_range(0, 9))
					// scroll: move_to followed by ticks, sometimes nudged by set_corner
					0, 1, 2, 3, 4, 5: begin
						send_word(KIND_MOVE_TO, rand_point(1'b1), rand_point(1'b0),
							rand_speed());
						done++;
						ticks = $urandom_range(1, 12);
						for (int j = 0; j < ticks && cam_speed != 0; j++) begin
							if ($urandom_range(0, 7) == 0) begin
								send_word(KIND_SET_CORNER, rand_point(1'b1),
									rand_point(1'b0), 8'($urandom_range(0, 255)));
							end else begin
								send_word(KIND_TICK, 16'($urandom_range(0, 65535)),
									16'($urandom_range(0, 65535)),
									8'($urandom_range(0, 255)));
							end
							done++;
						end
					end
					6: begin
						send_word(KIND_SET_CENTRE, rand_point(1'b1), rand_point(1'b0),
							8'($urandom_range(0, 255)));
						done++;
					end
					7: begin
						send_word(KIND_SET_CORNER, rand_point(1'b1), rand_point(1'b0),
							8'($urandom_range(0, 255)));
						done++;
					end
					// noise: any kind, any field values
					default: begin
						k = kind_t'($urandom_range(0, 3));
						if (k != KIND_TICK || cam_speed != 0) done++;
						send_word(k, 16'($urandom_range(0, 65535)),
							16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
					end
				endcase
			end
		end
	endtask

	// Result checker and pop driver
	always @(posedge clk) begin
		res_t exp_word;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (view_due.size() == 0) begin
					$error("result word with no expectation: view_x %0d view_y %0d moving %0d",
						view_x, view_y, moving);
					mismatches++;
				end else begin
					exp_word = view_due.pop_front();
					if (view_x !== exp_word.view_x) begin
						$error("view_x expected %0d actual %0d", exp_word.view_x, view_x);
						mismatches++;
					end
					if (view_y !== exp_word.view_y) begin
						$error("view_y expected %0d actual %0d", exp_word.view_y, view_y);
						mismatches++;
					end
					if (moving !== exp_word.moving) begin
						$error("moving expected %0d actual %0d", exp_word.moving, moving);
						mismatches++;
					end
					words_checked++;
				end
			end
			pop <= ($urandom_range(0, 99) >= pop_stall_pct);
		end
	end

	// Watchdog: no word moving on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
					idle_cycles, view_due.size());
				$display("tb_viewport_scroll_follower: FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_BOUNDS_LEFT;
		cfg_data <= '0;
		push <= 1'b0;
		pop <= 1'b0;
		kind <= KIND_TICK;
		coord_x <= '0;
		coord_y <= '0;
		step_speed <= '0;
		cfg_left = '0;
		cfg_top = '0;
		cfg_span_x = '0;
		cfg_span_y = '0;
		cfg_view_w = '0;
		cfg_view_h = '0;
		cam_x = '0;
		cam_y = '0;
		aim_x = '0;
		aim_y = '0;
		cam_speed = '0;
		send_idle_pct = 0;
		pop_stall_pct = 0;
		words_sent = 0;
		words_checked = 0;
		mismatches = 0;
		bounds_loaded = 0;
		idle_cycles = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_bounds();
		test_extremes();
		test_blocked_step();
		test_random_traffic(140, 0, 0);
		test_random_traffic(140, 47, 0);
		test_random_traffic(140, 0, 47);
		test_random_traffic(140, 34, 34);

		drain_results();
		repeat (8) @(posedge clk);
		$display("covered: reset bounds, field extremes, blocked steps, %0d bounds settings",
			bounds_loaded);
		$display("words sent %0d, results checked %0d, mismatches %0d",
			words_sent, words_checked, mismatches);
		if (mismatches == 0 && view_due.size() == 0) begin
			$display("tb_viewport_scroll_follower: PASS");
		end else begin
			$display("tb_viewport_scroll_follower: FAIL");
		end
		$finish;
	end

endmodule
